// ----- hdl/mixed_width_variable_store_rmw_unit_macros.svh -----
// Assertion macros used by the port-level checker of the variable store.
`ifndef MIXED_WIDTH_VARIABLE_STORE_RMW_UNIT_MACROS_SVH
`define MIXED_WIDTH_VARIABLE_STORE_RMW_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define MWVS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("variable store assertion failed");

// Property checked on every rising clock edge, also during reset.
`define MWVS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("variable store assertion failed");

`endif

// ----- hdl/mwvs_pkg.sv -----
// Package with the types, constants and helpers of the variable store.
package mwvs_pkg;

   // Each region holds this many entries; a row gathers one entry of each region.
   localparam int unsigned ROW_COUNT = 64;
   localparam int unsigned ROW_W     = $clog2(ROW_COUNT);

   // Last index of each region and the upper clamp bound of the byte region.
   localparam logic [15:0] FLAG_LAST = 16'h003f;
   localparam logic [15:0] BYTE_LAST = 16'h007f;
   localparam logic [15:0] WORD_LAST = 16'h00bf;
   localparam logic [15:0] BYTE_MAX  = 16'd255;

   // Operation codes of an input item.
   typedef enum logic [2:0] {
      OP_SET    = 3'd0,
      OP_CLEAR  = 3'd1,
      OP_TOGGLE = 3'd2,
      OP_ADD    = 3'd3,
      OP_SUB    = 3'd4,
      OP_KEEP   = 3'd5,
      OP_LOAD   = 3'd6,
      OP_HOLD   = 3'd7
   } op_mode_type;

   // Region that an index falls into.
   typedef enum logic [1:0] {
      REGION_FLAG,
      REGION_BYTE,
      REGION_WORD,
      REGION_NONE
   } region_type;

   // One memory row: the flag, byte and word that share the low index bits.
   typedef struct packed {
      logic [15:0] word_val;
      logic [7:0]  byte_val;
      logic        flag_val;
   } row_type;

   // Classify an index into its region.
   function automatic region_type region_of(input logic [15:0] idx);
      region_type r;
      if (idx <= FLAG_LAST) begin
         r = REGION_FLAG;
      end else if (idx <= BYTE_LAST) begin
         r = REGION_BYTE;
      end else if (idx <= WORD_LAST) begin
         r = REGION_WORD;
      end else begin
         r = REGION_NONE;
      end
      return r;
   endfunction

   // Clamp a 16-bit signed value to the byte range 0..255.
   function automatic logic [15:0] clamp_byte(input logic [15:0] v);
      logic [15:0] r;
      if (v[15]) begin
         r = '0;
      end else if (v > BYTE_MAX) begin
         r = BYTE_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- hdl/mwvs_if.sv -----
// Handshake interfaces of the request and response channels.

// Request channel: one read-modify-write command per transfer.
interface mwvs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] var_index;
   logic [2:0]  op_mode;
   logic signed [15:0] operand_value;

   modport source (output valid, output var_index, output op_mode, output operand_value,
                   input ready);
   modport sink (input valid, input var_index, input op_mode, input operand_value,
                 output ready);
endinterface

// Response channel: the new value of the variable, one per request.
interface mwvs_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] new_value;

   modport source (output valid, output new_value, input ready);
   modport sink (input valid, input new_value, output ready);
endinterface

// ----- hdl/mixed_width_variable_store_rmw_unit.sv -----
// Mixed-width variable store: 64 flags, 64 bytes and 64 words with read-modify-write.
//
// Usage:
//   req carries var_index, op_mode and operand_value; a transfer happens at a
//   rising edge with valid and ready high. rsp returns new_value, one transfer
//   per request, in request order.
//   Indices 0-63 address flags, 64-127 bytes (clamped to 0..255), 128-191
//   signed words; other indices read as zero and store nothing.
// Pipeline and throughput:
//   A request reads its row from a 64-row memory at the transfer edge into
//   the modify stage, which modifies and writes the row back and loads the
//   output register once that register is empty or rsp is ready; rsp.valid
//   comes straight from the output register.
//   One request per cycle is sustained while rsp is ready; a write to the same
//   row by the previous request is forwarded, so back-to-back updates see each other.
// Reset:
//   Synchronous, active high. A per-row valid bit is cleared, so every
//   variable reads as zero afterward; no clearing pass is needed.
// Stalls:
//   While rsp is stalled the output register holds; one more request can sit
//   in the modify stage, and then req.ready drops until the output drains.
module mixed_width_variable_store_rmw_unit (
   input  logic          clock,
   input  logic          reset,
   mwvs_req_if.sink      req,
   mwvs_rsp_if.source    rsp
);

   // Row memory and its per-row valid bits.
   mwvs_pkg::row_type rows_mem [mwvs_pkg::ROW_COUNT];
   logic [mwvs_pkg::ROW_COUNT-1:0] row_valid_ff, row_valid_in;

   // Modify stage registers.
   logic               s1_valid_ff, s1_valid_in;
   logic [15:0]        s1_index_ff;
   logic [2:0]         s1_mode_ff;
   logic [15:0]        s1_operand_ff;
   mwvs_pkg::row_type  rd_row_ff;
   logic               rd_valid_ff;
   logic               fwd_hit_ff;
   mwvs_pkg::row_type  fwd_row_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_value_ff;

   // Combinational signals.
   logic                          req_fire;
   logic                          s1_advance;
   logic                          wr_en;
   logic [mwvs_pkg::ROW_W-1:0]    req_row;
   logic [mwvs_pkg::ROW_W-1:0]    s1_row;
   mwvs_pkg::region_type          s1_region;
   mwvs_pkg::row_type             cur_row;
   mwvs_pkg::row_type             new_row;
   logic [15:0]                   cur_value;
   logic [15:0]                   res_value;
   logic [15:0]                   out_value;

   // Handshake control.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_advance;
   assign req_fire   = req.valid && req.ready;
   assign req_row    = req.var_index[mwvs_pkg::ROW_W-1:0];
   assign s1_row     = s1_index_ff[mwvs_pkg::ROW_W-1:0];
   assign s1_region  = mwvs_pkg::region_of(s1_index_ff);
   assign wr_en      = s1_advance && (s1_region != mwvs_pkg::REGION_NONE);

   // Current row: forwarded write, stored row, or zero for a never-written row.
   always_comb begin
      if (fwd_hit_ff) begin
         cur_row = fwd_row_ff;
      end else if (rd_valid_ff) begin
         cur_row = rd_row_ff;
      end else begin
         cur_row = '0;
      end
   end

   // Pick the addressed variable out of the row.
   always_comb begin
      unique case (s1_region)
         mwvs_pkg::REGION_FLAG: cur_value = {15'd0, cur_row.flag_val};
         mwvs_pkg::REGION_BYTE: cur_value = {8'd0, cur_row.byte_val};
         mwvs_pkg::REGION_WORD: cur_value = cur_row.word_val;
         default:               cur_value = '0;
      endcase
   end

   // Apply the operation; arithmetic wraps at 16 bits.
   always_comb begin
      unique case (mwvs_pkg::op_mode_type'(s1_mode_ff))
         mwvs_pkg::OP_SET:    res_value = 16'd1;
         mwvs_pkg::OP_CLEAR:  res_value = 16'd0;
         mwvs_pkg::OP_TOGGLE: res_value = (cur_value != 16'd0) ? 16'd0 : 16'd1;
         mwvs_pkg::OP_ADD:    res_value = cur_value + s1_operand_ff;
         mwvs_pkg::OP_SUB:    res_value = cur_value - s1_operand_ff;
         mwvs_pkg::OP_LOAD:   res_value = s1_operand_ff;
         default:             res_value = cur_value;
      endcase
   end

   // Normalize into the region's width and build the row to write back.
   always_comb begin
      new_row   = cur_row;
      out_value = res_value;
      unique case (s1_region)
         mwvs_pkg::REGION_FLAG: begin
            new_row.flag_val = (res_value != 16'd0);
         end
         mwvs_pkg::REGION_BYTE: begin
            out_value        = mwvs_pkg::clamp_byte(res_value);
            new_row.byte_val = out_value[7:0];
         end
         mwvs_pkg::REGION_WORD: begin
            new_row.word_val = res_value;
         end
         default: begin
            new_row = cur_row;
         end
      endcase
   end

   // Memory write-back and registered read of the incoming request's row.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_mem[s1_row] <= new_row;
      end
      if (req_fire) begin
         rd_row_ff <= rows_mem[req_row];
      end
   end

   // Valid bits: set on write, cleared at reset.
   always_comb begin
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[s1_row] = 1'b1;
      end
   end

   // Stage valid flags.
   always_comb begin
      s1_valid_in  = req_fire || (s1_valid_ff && !s1_advance);
      rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp.ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload, stored valid bit and forwarding capture at the transfer.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_index_ff   <= req.var_index;
         s1_mode_ff    <= req.op_mode;
         s1_operand_ff <= req.operand_value;
         rd_valid_ff   <= row_valid_ff[req_row];
         fwd_hit_ff    <= wr_en && (s1_row == req_row);
         fwd_row_ff    <= new_row;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_value_ff <= out_value;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.new_value = rsp_value_ff;

endmodule

// ----- hdl/mwvs_checker.sv -----
// Port-level checker of the variable store and its bind to the top level.
`include "mixed_width_variable_store_rmw_unit_macros.svh"

module mwvs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_new_value
);

   // A stalled response keeps its value.
   `MWVS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_value))

   // No response is pending in the cycle after reset.
   `MWVS_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

   // With the output empty the block always takes a request.
   `MWVS_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready)

   // A request whose response path is free passes the modify stage into the output register, where rsp.valid shows it.
   `MWVS_ASSERT(a_latency, clock, reset, req_valid && req_ready ##1 rsp_ready |=> rsp_valid)

endmodule

bind mixed_width_variable_store_rmw_unit mwvs_checker u_mwvs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_new_value (rsp.new_value)
);

// ----- verif/mwvs_store_checker.sv -----
// Checker that predicts every response of the variable store and compares its new_value.
module mwvs_store_checker (
   input  logic clock,
   input  logic reset,
   mwvs_req_if  req,
   mwvs_rsp_if  rsp,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import mwvs_pkg::*;

   // One request that is still waiting for its response.
   typedef struct {
      logic [15:0] index;
      op_mode_type mode;
      logic [15:0] value;
   } update_record_type;

   // Shadow copy of the three regions.
   logic        flag_mem [0:63];
   logic [7:0]  byte_mem [0:63];
   logic [15:0] word_mem [0:63];

   update_record_type expected_updates[$];
   int                mismatch_total = 0;

   // Apply one read-modify-write to the shadow stores and return the new value.
   // The entry inside every region is the low six bits of the index.
   function automatic logic [15:0] apply_update(input logic [15:0] idx,
                                                input op_mode_type mode,
                                                input logic [15:0] opnd);
      logic [15:0] cur;
      logic [15:0] nxt;
      cur = 16'h0000;
      if (idx <= FLAG_LAST) begin
         cur = {15'b0, flag_mem[idx[5:0]]};
      end else if (idx <= BYTE_LAST) begin
         cur = {8'b0, byte_mem[idx[5:0]]};
      end else if (idx <= WORD_LAST) begin
         cur = word_mem[idx[5:0]];
      end

      case (mode)
         OP_SET:    nxt = 16'd1;
         OP_CLEAR:  nxt = 16'd0;
         OP_TOGGLE: nxt = (cur != 16'd0) ? 16'd0 : 16'd1;
         OP_ADD:    nxt = cur + opnd;
         OP_SUB:    nxt = cur - opnd;
         OP_LOAD:   nxt = opnd;
         default:   nxt = cur;
      endcase

      // Flags keep only whether the value is nonzero, bytes saturate, words store as is.
      if (idx <= FLAG_LAST) begin
         flag_mem[idx[5:0]] = (nxt != 16'd0);
      end else if (idx <= BYTE_LAST) begin
         if (nxt[15]) begin
            nxt = 16'd0;
         end else if (nxt > BYTE_MAX) begin
            nxt = BYTE_MAX;
         end
         byte_mem[idx[5:0]] = nxt[7:0];
      end else if (idx <= WORD_LAST) begin
         word_mem[idx[5:0]] = nxt;
      end
      return nxt;
   endfunction

   // Predict on every request transfer and check on every response transfer.
   always @(posedge clock) begin
      update_record_type sent;
      update_record_type due;
      if (reset) begin
         for (int i = 0; i < 64; i++) begin
            flag_mem[i] = 1'b0;
            byte_mem[i] = 8'h00;
            word_mem[i] = 16'h0000;
         end
         expected_updates.delete();
      end else begin
         if (req.valid && req.ready) begin
            sent.index = req.var_index;
            sent.mode  = op_mode_type'(req.op_mode);
            sent.value = apply_update(req.var_index, op_mode_type'(req.op_mode),
                                      req.operand_value);
            expected_updates.push_back(sent);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_updates.size() == 0) begin
               $display("%0t: unexpected response, expected none, got new_value %h",
                        $time, rsp.new_value);
               mismatch_total++;
            end else begin
               due = expected_updates.pop_front();
               if (rsp.new_value !== due.value) begin
                  $display("%0t: new_value mismatch for index %h mode %s: expected %h, got %h",
                           $time, due.index, due.mode.name(), due.value, rsp.new_value);
                  mismatch_total++;
               end
            end
         end
      end
      fail_count    <= mismatch_total;
      pending_count <= expected_updates.size();
   end

endmodule

// ----- verif/tb_mixed_width_variable_store_rmw_unit.sv -----
// Testbench top that drives the variable store and reports the verdict.
module tb_mixed_width_variable_store_rmw_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mwvs_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int          fail_count;
   int          pending_count;
   int          source_idle_pct = 0;
   int          sink_idle_pct   = 0;
   int unsigned cycle_count     = 0;
   logic [15:0] last_index      = 16'h0000;

   mwvs_req_if req_bus ();
   mwvs_rsp_if rsp_bus ();

   mixed_width_variable_store_rmw_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   mwvs_store_checker store_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Clock with a 4 ns period.
   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   // Give up if the run takes far longer than the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mixed_width_variable_store_rmw_unit verification failed");
         $finish;
      end
   end

   // Response side: ready drops at random with the current idle share.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // Present one request, with random idle cycles ahead of it, and wait for its transfer.
   task automatic send_request(input logic [15:0] idx, input op_mode_type mode,
                               input logic [15:0] opnd);
      while ($urandom_range(99) < source_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.var_index     <= idx;
      req_bus.op_mode       <= mode;
      req_bus.operand_value <= opnd;
      last_index = idx;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // Random requests: mostly mapped indices, often repeating the previous one
   // so that back-to-back updates of one variable are common.
   task automatic send_random(input int count);
      logic [15:0] idx;
      logic [15:0] opnd;
      op_mode_type mode;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            idx = last_index;
         end else if (pick < 87) begin
            idx = 16'($urandom_range(191));
         end else begin
            idx = 16'($urandom_range(65535, 192));
         end
         case ($urandom_range(9))
            0:       opnd = 16'h8000;
            1:       opnd = 16'h7fff;
            2:       opnd = 16'hffff;
            3:       opnd = 16'h0000;
            4, 5:    opnd = 16'($urandom_range(512)) - 16'd256;
            default: opnd = 16'($urandom());
         endcase
         mode = op_mode_type'($urandom_range(7));
         send_request(idx, mode, opnd);
      end
   endtask

   // Stimulus: reset, directed corner cases, then random traffic in three idle patterns.
   initial begin
      req_bus.valid         <= 1'b0;
      req_bus.var_index     <= 16'h0000;
      req_bus.op_mode       <= OP_KEEP;
      req_bus.operand_value <= 16'h0000;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      source_idle_pct = 33;
      sink_idle_pct  <= 73;

      // Flags: read after reset, toggling, and results that are stored only as nonzero.
      send_request(16'd0,   OP_KEEP,   16'h1234);
      send_request(16'd0,   OP_SET,    16'h0000);
      send_request(16'd0,   OP_TOGGLE, 16'h0000);
      send_request(16'd0,   OP_TOGGLE, 16'h0000);
      send_request(16'd63,  OP_ADD,    16'h7fff);
      send_request(16'd63,  OP_SUB,    16'h0001);
      send_request(16'd5,   OP_LOAD,   16'hffff);
      send_request(16'd5,   OP_ADD,    16'h0001);

      // Bytes: clamping at both ends and the hold code.
      send_request(16'd64,  OP_LOAD,   16'd300);
      send_request(16'd64,  OP_ADD,    16'hff00);
      send_request(16'd127, OP_LOAD,   16'h7fff);
      send_request(16'd127, OP_SUB,    16'h8000);
      send_request(16'd100, OP_LOAD,   16'd200);
      send_request(16'd100, OP_ADD,    16'd55);
      send_request(16'd100, OP_HOLD,   16'h5555);
      send_request(16'd100, OP_TOGGLE, 16'h0000);

      // Words: signed wrap in both directions.
      send_request(16'd128, OP_LOAD,   16'h7fff);
      send_request(16'd128, OP_ADD,    16'h0001);
      send_request(16'd128, OP_SUB,    16'h0001);
      send_request(16'd191, OP_LOAD,   16'h8000);
      send_request(16'd191, OP_SUB,    16'h8000);
      send_request(16'd150, OP_SET,    16'h0000);
      send_request(16'd150, OP_CLEAR,  16'h0000);

      // Unmapped indices read as zero and store nothing.
      send_request(16'd192,   OP_LOAD, 16'd1234);
      send_request(16'hffff,  OP_ADD,  16'd5);
      send_request(16'hffff,  OP_KEEP, 16'hffff);

      send_random(RANDOM_ITEMS / 3);

      source_idle_pct = 73;
      sink_idle_pct  <= 33;
      send_random(RANDOM_ITEMS / 3);

      source_idle_pct = 0;
      sink_idle_pct  <= 0;
      send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

      // The last transfer has happened; let the checker record it, then drain.
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("mixed_width_variable_store_rmw_unit verification clean");
      end else begin
         $display("mixed_width_variable_store_rmw_unit verification failed");
      end
      $finish;
   end

endmodule
